FILE: hw/rtl/ssr_pkg.sv
// Shared constants and types for the stream search-and-replace block.
// Holds the configuration register layout and register index codes.
// No dependencies.
package ssr_pkg;

    localparam int MAX_SEARCH_DEF  = 8;
    localparam int MAX_REPLACE_DEF = 8;

    localparam int BYTE_W    = 8;
    localparam int LEN_W     = 4;
    localparam int STR_W     = 64;
    localparam int CFG_IDX_W = 2;

    localparam logic [BYTE_W-1:0] NEWLINE_BYTE = 8'h0A;

    localparam logic [CFG_IDX_W-1:0] REG_SEARCH_LEN    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SEARCH_BYTES  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REPLACE_LEN   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REPLACE_BYTES = 2'd3;

    typedef struct packed {
        logic [STR_W-1:0] replace_bytes;
        logic [LEN_W-1:0] replace_len;
        logic [STR_W-1:0] search_bytes;
        logic [LEN_W-1:0] search_len;
    } cfg_t;

endpackage

FILE: hw/rtl/ssr_out_cell.sv
// One cell of the result chain: holds one pending result byte and its last flag.
// Loads in parallel on an accepted input beat and otherwise shifts from its neighbor.
// Depends on ssr_pkg.
module ssr_out_cell (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       load,
    input  logic                       shift,
    input  logic                       load_valid,
    input  logic [ssr_pkg::BYTE_W-1:0] load_byte,
    input  logic                       load_last,
    input  logic                       next_valid,
    input  logic [ssr_pkg::BYTE_W-1:0] next_byte,
    input  logic                       next_last,
    output logic                       cell_valid,
    output logic [ssr_pkg::BYTE_W-1:0] cell_byte,
    output logic                       cell_last
);
    import ssr_pkg::*;

    logic              valid_reg;
    logic [BYTE_W-1:0] byte_reg;
    logic              last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= load_valid;
        end else if (shift) begin
            valid_reg <= next_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            byte_reg <= load_byte;
            last_reg <= load_last;
        end else if (shift) begin
            byte_reg <= next_byte;
            last_reg <= next_last;
        end
    end

    assign cell_valid = valid_reg;
    assign cell_byte  = byte_reg;
    assign cell_last  = last_reg;

endmodule

FILE: hw/rtl/ssr_match.sv
// Match step logic: forms the candidate from held bytes and the new byte,
// finds the longest suffix that is still a search prefix, and builds the result bytes.
// Depends on ssr_pkg.
module ssr_match #(
    parameter int MAX_SEARCH  = ssr_pkg::MAX_SEARCH_DEF,
    parameter int MAX_REPLACE = ssr_pkg::MAX_REPLACE_DEF,
    localparam int CNT_W      = $clog2(MAX_SEARCH + 1),
    localparam int OUT_DEPTH  = (MAX_SEARCH > MAX_REPLACE) ? MAX_SEARCH : MAX_REPLACE
) (
    input  ssr_pkg::cfg_t                          cfg,
    input  logic [ssr_pkg::BYTE_W*MAX_SEARCH-1:0]  held_bytes,
    input  logic [CNT_W-1:0]                       held_count,
    input  logic                                   line_open,
    input  logic [ssr_pkg::BYTE_W-1:0]             in_byte,
    input  logic                                   is_flush,
    output logic [ssr_pkg::BYTE_W*MAX_SEARCH-1:0]  held_bytes_next,
    output logic [CNT_W-1:0]                       held_count_next,
    output logic                                   line_open_next,
    output logic [ssr_pkg::BYTE_W*OUT_DEPTH-1:0]   out_bytes,
    output logic [OUT_DEPTH-1:0]                   out_mask
);
    import ssr_pkg::*;

    localparam int RL_W = $clog2(MAX_REPLACE + 1);

    logic [BYTE_W*MAX_SEARCH-1:0] cand;
    logic [CNT_W-1:0]             len_eff;
    logic [RL_W-1:0]              rlen_eff;
    logic [CNT_W-1:0]             cand_len;
    logic [MAX_SEARCH-1:0]        prefix_ok;
    logic [CNT_W-1:0]             start;
    logic                         full_match;
    logic [BYTE_W*MAX_SEARCH-1:0] shifted;

    assign len_eff  = (cfg.search_len > LEN_W'(MAX_SEARCH)) ? CNT_W'(MAX_SEARCH)
                                                            : CNT_W'(cfg.search_len);
    assign rlen_eff = (cfg.replace_len > LEN_W'(MAX_REPLACE)) ? RL_W'(MAX_REPLACE)
                                                              : RL_W'(cfg.replace_len);
    assign cand_len = held_count + CNT_W'(1);

    always_comb begin
        cand = held_bytes;
        for (int i = 0; i < MAX_SEARCH; i++) begin
            if (CNT_W'(i) == held_count) begin
                cand[BYTE_W*i +: BYTE_W] = in_byte;
            end
        end
    end

    always_comb begin
        for (int s = 0; s < MAX_SEARCH; s++) begin
            prefix_ok[s] = (CNT_W'(s) < cand_len);
            for (int k = 0; k < MAX_SEARCH - s; k++) begin
                if ((CNT_W'(s + k) < cand_len) &&
                    (cand[BYTE_W*(s+k) +: BYTE_W] != cfg.search_bytes[BYTE_W*k +: BYTE_W])) begin
                    prefix_ok[s] = 1'b0;
                end
            end
        end
    end

    always_comb begin
        start = cand_len;
        for (int s = MAX_SEARCH - 1; s >= 0; s--) begin
            if (prefix_ok[s]) begin
                start = CNT_W'(s);
            end
        end
    end

    assign full_match = (cand_len == len_eff) && prefix_ok[0];

    always_comb begin
        shifted = held_bytes;
        for (int s = 0; s < MAX_SEARCH; s++) begin
            if (start == CNT_W'(s)) begin
                for (int i = 0; i < MAX_SEARCH - s; i++) begin
                    shifted[BYTE_W*i +: BYTE_W] = cand[BYTE_W*(s+i) +: BYTE_W];
                end
            end
        end
    end

    always_comb begin
        held_bytes_next = held_bytes;
        held_count_next = held_count;
        line_open_next  = 1'b1;
        out_bytes       = '0;
        out_mask        = '0;
        if (is_flush || (in_byte == NEWLINE_BYTE)) begin
            for (int i = 0; i < MAX_SEARCH; i++) begin
                out_bytes[BYTE_W*i +: BYTE_W] = held_bytes[BYTE_W*i +: BYTE_W];
                out_mask[i] = (CNT_W'(i) < held_count);
                if (CNT_W'(i) == held_count) begin
                    out_bytes[BYTE_W*i +: BYTE_W] = NEWLINE_BYTE;
                    out_mask[i] = !is_flush || line_open;
                end
            end
            held_count_next = '0;
            line_open_next  = 1'b0;
        end else if (len_eff == '0) begin
            out_bytes[BYTE_W-1:0] = in_byte;
            out_mask[0]           = 1'b1;
        end else if (full_match) begin
            for (int i = 0; i < MAX_REPLACE; i++) begin
                out_bytes[BYTE_W*i +: BYTE_W] = cfg.replace_bytes[BYTE_W*i +: BYTE_W];
                out_mask[i] = (RL_W'(i) < rlen_eff);
            end
            held_count_next = '0;
        end else begin
            for (int i = 0; i < MAX_SEARCH; i++) begin
                out_bytes[BYTE_W*i +: BYTE_W] = cand[BYTE_W*i +: BYTE_W];
                out_mask[i] = (CNT_W'(i) < start);
            end
            held_bytes_next = shifted;
            held_count_next = cand_len - start;
        end
    end

endmodule

FILE: hw/rtl/stream_search_replace_top.sv
// Top level of the stream search-and-replace block: configuration registers,
// held-prefix state, match logic and the chain of result cells.
// Depends on ssr_pkg, ssr_match and ssr_out_cell.
// The first result beat of an input beat appears in the cycle after the input beat is accepted.
// Throughput: while m_tready is high the result chain drains one beat per cycle and beats
// with zero or one result go at one per cycle; a longer result holds off the next input beat.
// Reset: synchronous, active low; clears the registers, the held count, the line flag
// and the result chain. The block is ready as soon as reset is released.
module stream_search_replace_top #(
    parameter int MAX_SEARCH  = ssr_pkg::MAX_SEARCH_DEF,
    parameter int MAX_REPLACE = ssr_pkg::MAX_REPLACE_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [ssr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ssr_pkg::STR_W-1:0]     cfg_data,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // in_byte
    input  logic                          s_tuser,   // is_flush
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [7:0]                    m_tdata,   // out_byte
    output logic                          m_tlast    // out_last
);
    import ssr_pkg::*;

    localparam int CNT_W     = $clog2(MAX_SEARCH + 1);
    localparam int OUT_DEPTH = (MAX_SEARCH > MAX_REPLACE) ? MAX_SEARCH : MAX_REPLACE;

    cfg_t                         cfg_reg;
    logic [BYTE_W*MAX_SEARCH-1:0] held_reg;
    logic [BYTE_W*MAX_SEARCH-1:0] held_next;
    logic [CNT_W-1:0]             held_count_reg;
    logic [CNT_W-1:0]             held_count_next;
    logic                         line_open_reg;
    logic                         line_open_next;
    logic [BYTE_W*OUT_DEPTH-1:0]  out_bytes;
    logic [OUT_DEPTH-1:0]         out_mask;

    logic [OUT_DEPTH:0]           chain_valid;
    logic [BYTE_W-1:0]            chain_byte [OUT_DEPTH+1];
    logic [OUT_DEPTH:0]           chain_last;

    logic in_beat;
    logic out_beat;

    assign out_beat = m_tvalid && m_tready;
    assign s_tready = !chain_valid[0] || (!chain_valid[1] && m_tready);
    assign in_beat  = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_SEARCH_LEN:    cfg_reg.search_len    <= cfg_data[LEN_W-1:0];
                REG_SEARCH_BYTES:  cfg_reg.search_bytes  <= cfg_data;
                REG_REPLACE_LEN:   cfg_reg.replace_len   <= cfg_data[LEN_W-1:0];
                REG_REPLACE_BYTES: cfg_reg.replace_bytes <= cfg_data;
                default:           cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_count_reg <= '0;
            line_open_reg  <= 1'b0;
        end else if (cfg_we &&
                     (cfg_index == REG_SEARCH_LEN || cfg_index == REG_SEARCH_BYTES)) begin
            held_count_reg <= '0;
        end else if (in_beat) begin
            held_count_reg <= held_count_next;
            line_open_reg  <= line_open_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_beat) begin
            held_reg <= held_next;
        end
    end

    ssr_match #(
        .MAX_SEARCH  (MAX_SEARCH),
        .MAX_REPLACE (MAX_REPLACE)
    ) u_match (
        .cfg             (cfg_reg),
        .held_bytes      (held_reg),
        .held_count      (held_count_reg),
        .line_open       (line_open_reg),
        .in_byte         (s_tdata),
        .is_flush        (s_tuser),
        .held_bytes_next (held_next),
        .held_count_next (held_count_next),
        .line_open_next  (line_open_next),
        .out_bytes       (out_bytes),
        .out_mask        (out_mask)
    );

    assign chain_valid[OUT_DEPTH] = 1'b0;
    assign chain_byte[OUT_DEPTH]  = '0;
    assign chain_last[OUT_DEPTH]  = 1'b0;

    for (genvar i = 0; i < OUT_DEPTH; i++) begin : g_cell
        logic is_last;

        if (i == OUT_DEPTH - 1) begin : g_end
            assign is_last = out_mask[i];
        end else begin : g_mid
            assign is_last = out_mask[i] && !out_mask[i+1];
        end

        ssr_out_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .load       (in_beat),
            .shift      (out_beat),
            .load_valid (out_mask[i]),
            .load_byte  (out_bytes[BYTE_W*i +: BYTE_W]),
            .load_last  (is_last),
            .next_valid (chain_valid[i+1]),
            .next_byte  (chain_byte[i+1]),
            .next_last  (chain_last[i+1]),
            .cell_valid (chain_valid[i]),
            .cell_byte  (chain_byte[i]),
            .cell_last  (chain_last[i])
        );
    end

    assign m_tvalid = chain_valid[0];
    assign m_tdata  = chain_byte[0];
    assign m_tlast  = chain_last[0];

endmodule
